### rtl/mfq_pkg.sv
package mfq_pkg;

    // Function codes of an input transaction.
    localparam logic FUNC_ACQUIRE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK_SELF,
        ST_POP,
        ST_FIN
    } t_state;

    // Work that follows the execute step.
    typedef enum logic [1:0] {
        PATH_DONE,
        PATH_APPEND,
        PATH_POP
    } t_path;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic self_clear;
        logic pop;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_path path;
        logic  out_free;
    } t_status;

endpackage

### rtl/mfq_ram.sv
module mfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; a read in the cycle of a
    // write to the same address returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mfq_ctrl.sv
module mfq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mfq_pkg::t_status i_status,
    output mfq_pkg::t_cmd    o_cmd
);

    mfq_pkg::t_state r_state;
    mfq_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            mfq_pkg::ST_IDLE: begin
                // A new transaction is taken even while the previous result
                // still sits in the output register.
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = mfq_pkg::ST_EXEC;
                end
            end
            mfq_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_status.path)
                    mfq_pkg::PATH_APPEND: n_state = mfq_pkg::ST_LINK_SELF;
                    mfq_pkg::PATH_POP:    n_state = mfq_pkg::ST_POP;
                    default:              n_state = mfq_pkg::ST_FIN;
                endcase
            end
            mfq_pkg::ST_LINK_SELF: begin
                o_cmd.self_clear = 1'b1;
                n_state          = mfq_pkg::ST_FIN;
            end
            mfq_pkg::ST_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = mfq_pkg::ST_FIN;
            end
            mfq_pkg::ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = mfq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mfq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/mfq_dpath.sv
module mfq_dpath #(
    parameter int SLOTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mfq_pkg::t_cmd    i_cmd,
    output mfq_pkg::t_status o_status,
    input  logic             i_func,
    input  logic [5:0]       i_requester,
    input  logic [30:0]      i_owner_id,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_granted,
    output logic             o_queued,
    output logic             o_wake_valid,
    output logic [5:0]       o_wake_slot
);

    // Link values run from 0 to SLOTS; SLOTS itself marks an empty link.
    localparam int LW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = ((LW > 6) ? LW : 6) + 1;
    localparam logic [LW-1:0] LINK_NONE = LW'(SLOTS);

    // Captured transaction.
    logic        r_func;
    logic [5:0]  r_req;
    logic [30:0] r_oid;

    // Mutex state.
    logic          r_lock_held;
    logic [30:0]   r_owner_pid;
    logic [LW-1:0] r_head;
    logic [LW-1:0] r_tail;

    // Pending result and output register.
    logic       r_res_granted;
    logic       r_res_queued;
    logic       r_res_wake_valid;
    logic [5:0] r_res_wake_slot;
    logic       r_out_valid;
    logic       r_out_granted;
    logic       r_out_queued;
    logic       r_out_wake_valid;
    logic [5:0] r_out_wake_slot;

    // Link memory port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic [LW-1:0] ram_rdata;

    logic head_empty;
    logic tail_empty;
    logic req_in_range;
    logic next_empty;

    assign head_empty   = (r_head >= LINK_NONE);
    assign tail_empty   = (r_tail >= LINK_NONE);
    assign req_in_range = (CW'(r_req) < CW'(SLOTS));
    assign next_empty   = (ram_rdata >= LINK_NONE);

    // Decide the work that follows the execute step, and report whether the
    // output register can take a result.
    always_comb begin
        o_status.out_free = !r_out_valid || i_ready;
        if (r_func == mfq_pkg::FUNC_ACQUIRE) begin
            if (r_lock_held && req_in_range) begin
                o_status.path = mfq_pkg::PATH_APPEND;
            end else begin
                o_status.path = mfq_pkg::PATH_DONE;
            end
        end else if (!head_empty) begin
            o_status.path = mfq_pkg::PATH_POP;
        end else begin
            o_status.path = mfq_pkg::PATH_DONE;
        end
    end

    // Link memory writes: the old tail's link on an append, then the new
    // tail's own link; the popped head's link on a pop. The memory is not
    // cleared after reset, since a slot's link is always written when the
    // slot is appended, before the slot can become the head and be read.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_req);
        ram_wdata = LINK_NONE;
        if (i_cmd.exec && (o_status.path == mfq_pkg::PATH_APPEND)
            && !head_empty && !tail_empty) begin
            ram_we    = 1'b1;
            ram_waddr = r_tail[AW-1:0];
            ram_wdata = LW'(r_req);
        end else if (i_cmd.self_clear) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_req);
            ram_wdata = LINK_NONE;
        end else if (i_cmd.pop) begin
            ram_we    = 1'b1;
            ram_waddr = r_head[AW-1:0];
            ram_wdata = LINK_NONE;
        end
    end

    // The read port always looks at the head's link, so the next waiter is
    // ready in the cycle after the execute step.
    mfq_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Transaction capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_req  <= i_requester;
            r_oid  <= i_owner_id;
        end
    end

    // Lock, owner, head and tail.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_held <= 1'b0;
            r_owner_pid <= '0;
            r_head      <= LINK_NONE;
            r_tail      <= LINK_NONE;
        end else if (i_cmd.exec) begin
            if (r_func == mfq_pkg::FUNC_ACQUIRE) begin
                if (!r_lock_held) begin
                    r_lock_held <= 1'b1;
                    r_owner_pid <= r_oid;
                end else if (req_in_range) begin
                    if (head_empty) begin
                        r_head <= LW'(r_req);
                    end
                    r_tail <= LW'(r_req);
                end
            end else begin
                r_lock_held <= 1'b0;
                r_owner_pid <= '0;
            end
        end else if (i_cmd.pop) begin
            r_head <= ram_rdata;
            if (next_empty) begin
                r_tail <= LINK_NONE;
            end
        end
    end

    // Pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_granted    <= (r_func == mfq_pkg::FUNC_ACQUIRE) && !r_lock_held;
            r_res_queued     <= (r_func == mfq_pkg::FUNC_ACQUIRE) && r_lock_held
                                && req_in_range;
            r_res_wake_valid <= 1'b0;
            r_res_wake_slot  <= '0;
        end else if (i_cmd.pop) begin
            r_res_wake_valid <= 1'b1;
            r_res_wake_slot  <= 6'(r_head);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_granted    <= r_res_granted;
            r_out_queued     <= r_res_queued;
            r_out_wake_valid <= r_res_wake_valid;
            r_out_wake_slot  <= r_res_wake_slot;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_granted    = r_out_granted;
    assign o_queued     = r_out_queued;
    assign o_wake_valid = r_out_wake_valid;
    assign o_wake_slot  = r_out_wake_slot;

endmodule

### rtl/mutex_with_fifo_waiter_queue.sv
// Steps per transaction: acceptance in idle, an execute step, one link or
// pop step for a queued acquire or a wakeup, and a finish that loads the
// output register and sets o_valid; the finish waits while an untaken result
// sits there, and the next transaction is taken only after the finish.
// Reset (i_rst_n low, synchronous) frees the lock, empties the queue and the
// output register; no clearing pass, a transaction is taken right after reset.
module mutex_with_fifo_waiter_queue #(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [5:0]  i_requester,
    input  logic [30:0] i_owner_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_granted,
    output logic        o_queued,
    output logic        o_wake_valid,
    output logic [5:0]  o_wake_slot
);

    mfq_pkg::t_cmd    cmd;
    mfq_pkg::t_status status;

    // Sequencer.
    mfq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Lock state, waiter list and result registers.
    mfq_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_func       (i_func),
        .i_requester  (i_requester),
        .i_owner_id   (i_owner_id),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_granted    (o_granted),
        .o_queued     (o_queued),
        .o_wake_valid (o_wake_valid),
        .o_wake_slot  (o_wake_slot)
    );

endmodule

### rtl/mfq_checker.sv
module mfq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_granted,
    input logic       o_queued,
    input logic       o_wake_valid,
    input logic [5:0] o_wake_slot
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_granted) && $stable(o_queued)
            && $stable(o_wake_valid) && $stable(o_wake_slot))
        else $error("result changed while stalled");

    // A transaction has exactly one outcome at most.
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_granted, o_queued, o_wake_valid}))
        else $error("more than one outcome in a result");

    // The wake slot reads zero without a wakeup.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_wake_valid |-> o_wake_slot == 6'd0)
        else $error("wake slot set without a wakeup");

    // Reset drops any pending result.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind mutex_with_fifo_waiter_queue mfq_checker u_mfq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_granted    (o_granted),
    .o_queued     (o_queued),
    .o_wake_valid (o_wake_valid),
    .o_wake_slot  (o_wake_slot)
);
